@@ sv/rr_pkg.sv @@
package rr_pkg;

  // fixed-point coordinate wide enough for a Q11.8 edge sum and a pixel
  // position of up to 4096 columns in Q8
  localparam int unsigned CoordW = 22;
  localparam int unsigned OneQ8 = 256;

  localparam logic [7:0] SHAPE_OUTLINE = 8'h72;
  localparam logic [7:0] SHAPE_FILLED = 8'h52;

  // configuration register indexes
  localparam logic [1:0] REG_CANVAS_WIDTH = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BACKGROUND_CHAR = 2'd2;

  localparam logic [9:0] CANVAS_WIDTH_RST = 10'd1;
  localparam logic [9:0] CANVAS_HEIGHT_RST = 10'd1;
  localparam logic [7:0] BACKGROUND_CHAR_RST = 8'd32;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // command handed from the front end to the back end
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ,
    OP_REPLY
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       status;
    logic       filled;
    logic [7:0] paint;
    coord_t     x_lo;
    coord_t     x_hi;
    coord_t     x_in_lo;
    coord_t     x_in_hi;
    coord_t     y_lo;
    coord_t     y_hi;
    coord_t     y_in_lo;
    coord_t     y_in_hi;
    logic [8:0] read_col;
    logic [8:0] read_row;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_DRAW,
    BK_RMUL,
    BK_RMEM,
    BK_REPLY
  } back_state_e;

endpackage

@@ sv/rr_front.sv @@
module rr_front #(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CH = $clog2(MAX_HEIGHT + 1)
) (
  input  logic               [1:0]  kind_i,
  input  logic               [7:0]  shape_type_i,
  input  logic signed        [19:0] rect_x_i,
  input  logic signed        [19:0] rect_y_i,
  input  logic signed        [19:0] rect_width_i,
  input  logic signed        [19:0] rect_height_i,
  input  logic               [7:0]  paint_char_i,
  input  logic               [8:0]  read_col_i,
  input  logic               [8:0]  read_row_i,
  input  logic               [CW-1:0] cols_i,
  input  logic               [CH-1:0] rows_i,
  output rr_pkg::cmd_t              cmd_o
);
  import rr_pkg::*;

  coord_t rx, ry, right, bottom;
  logic   shape_ok, size_ok, read_ok;

  assign rx     = CoordW'(rect_x_i);
  assign ry     = CoordW'(rect_y_i);
  assign right  = rx + CoordW'(rect_width_i);
  assign bottom = ry + CoordW'(rect_height_i);

  assign shape_ok = (shape_type_i == SHAPE_OUTLINE) || (shape_type_i == SHAPE_FILLED);
  assign size_ok  = (rect_width_i > 20'sd0) && (rect_height_i > 20'sd0);
  assign read_ok  = (int'(read_col_i) < int'(cols_i)) && (int'(read_row_i) < int'(rows_i));

  always_comb begin
    cmd_o.status   = 1'b0;
    cmd_o.filled   = (shape_type_i == SHAPE_FILLED);
    cmd_o.paint    = paint_char_i;
    // bounds of the rectangle and of its interior one unit in from each edge
    cmd_o.x_lo     = rx;
    cmd_o.x_hi     = right;
    cmd_o.x_in_lo  = rx + coord_t'(OneQ8);
    cmd_o.x_in_hi  = right - coord_t'(OneQ8);
    cmd_o.y_lo     = ry;
    cmd_o.y_hi     = bottom;
    cmd_o.y_in_lo  = ry + coord_t'(OneQ8);
    cmd_o.y_in_hi  = bottom - coord_t'(OneQ8);
    cmd_o.read_col = read_col_i;
    cmd_o.read_row = read_row_i;
    case (kind_i)
      KIND_CLEAR: cmd_o.op = OP_CLEAR;
      KIND_DRAW: begin
        if (shape_ok && size_ok) begin
          cmd_o.op = OP_DRAW;
        end else begin
          cmd_o.op     = OP_REPLY;
          cmd_o.status = 1'b1;
        end
      end
      KIND_READ: cmd_o.op = read_ok ? OP_READ : OP_REPLY;
      default:   cmd_o.op = OP_REPLY;
    endcase
  end

endmodule

@@ sv/rr_cmd_fifo.sv @@
module rr_cmd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rr_pkg::cmd_t push_cmd_i,
  input  logic         pop_i,
  output rr_pkg::cmd_t head_cmd_o,
  output logic         full_o,
  output logic         empty_o
);
  import rr_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t            entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;

  assign full_o     = (count_q == (PtrW+1)'(Depth));
  assign empty_o    = (count_q == '0);
  assign head_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ sv/rr_back.sv @@
module rr_back #(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned CH = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rr_pkg::cmd_t        head_cmd_i,
  input  logic                empty_i,
  output logic                pop_o,
  input  logic [CW-1:0]       cols_i,
  input  logic [CH-1:0]       rows_i,
  input  logic [7:0]          background_char_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          cell_char_o,
  output logic                status_o
);
  import rr_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PW = 9 + CW;

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [AW-1:0] addr_q;
  logic [PW-1:0] prod_q;
  logic [7:0]    mem [Depth];
  logic [7:0]    rdata_q;
  logic          out_valid_q;
  logic [7:0]    cell_char_q;
  logic          status_q;

  logic          out_free, last_col, last_row, last_cell, paint_hit;
  logic          sweep, mem_we, rd_en, out_load;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] rd_addr;
  coord_t        px, py;
  logic          in_x, in_y, edge_x, edge_y;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_col  = (CW'(col_q) == cols_i - CW'(1));
  assign last_row  = (CH'(row_q) == rows_i - CH'(1));
  assign last_cell = last_col && last_row;

  // cell position in Q8
  assign px = signed'({{(CoordW - XW - 8){1'b0}}, col_q, 8'h00});
  assign py = signed'({{(CoordW - YW - 8){1'b0}}, row_q, 8'h00});

  assign in_x   = (px >= cmd_q.x_lo) && (px <= cmd_q.x_hi);
  assign in_y   = (py >= cmd_q.y_lo) && (py <= cmd_q.y_hi);
  assign edge_x = (px < cmd_q.x_in_lo) || (px > cmd_q.x_in_hi);
  assign edge_y = (py < cmd_q.y_in_lo) || (py > cmd_q.y_in_hi);
  assign paint_hit = in_x && in_y && (cmd_q.filled || edge_x || edge_y);

  assign rd_addr = AW'(prod_q + PW'(cmd_q.read_col));

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          case (head_cmd_i.op)
            OP_CLEAR: state_d = BK_CLEAR;
            OP_DRAW:  state_d = BK_DRAW;
            OP_READ:  state_d = BK_RMUL;
            default:  state_d = BK_REPLY;
          endcase
        end
      end
      BK_CLEAR, BK_DRAW: begin
        if (last_cell) begin
          state_d = BK_REPLY;
        end
      end
      BK_RMUL:  state_d = BK_RMEM;
      BK_RMEM:  state_d = BK_REPLY;
      BK_REPLY: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == BK_IDLE) && !empty_i;
    sweep     = (state_q == BK_CLEAR) || (state_q == BK_DRAW);
    mem_we    = (state_q == BK_CLEAR) || ((state_q == BK_DRAW) && paint_hit);
    mem_wdata = (state_q == BK_CLEAR) ? background_char_i : cmd_q.paint;
    rd_en     = (state_q == BK_RMEM);
    out_load  = (state_q == BK_REPLY) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= head_cmd_i;
      col_q  <= '0;
      row_q  <= '0;
      addr_q <= '0;
    end else if (sweep) begin
      // row-major scan, so the cell address just counts up
      addr_q <= addr_q + 1'b1;
      if (last_col) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
    if (state_q == BK_RMUL) begin
      prod_q <= PW'(cmd_q.read_row) * PW'(cols_i);
    end
    if (out_load) begin
      cell_char_q <= (cmd_q.op == OP_READ) ? rdata_q : 8'h00;
      status_q    <= cmd_q.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_char_o = cell_char_q;
  assign status_o    = status_q;

endmodule

@@ sv/rectangle_rasterizer_top.sv @@
// channel   direction  handshake               payload
// input     in         in_valid_i/in_stall_o   kind, shape, rect x/y/w/h, paint, read col/row
// output    out        out_valid_o/out_stall_i cell_char, status
// config    in         apb psel/penable/pwrite canvas width, height, background char
//
// clear and draw each sweep all rows*cols cells in the back end,
// one canvas cell per cycle through the single memory write port; a read goes
// through row*cols multiply, memory read and reply, and a rejected draw straight to reply
// reset clears control and config only; the canvas memory is not cleared and a
// read of a cell no clear or draw has written returns an arbitrary byte
// a two-beat command queue lets the input side keep taking beats, until it is
// full, while the back end sweeps or while a result waits on out_stall_i
module rectangle_rasterizer_top #(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         shape_type_i,
  input  logic signed [19:0] rect_x_i,
  input  logic signed [19:0] rect_y_i,
  input  logic signed [19:0] rect_width_i,
  input  logic signed [19:0] rect_height_i,
  input  logic [7:0]         paint_char_i,
  input  logic [8:0]         read_col_i,
  input  logic [8:0]         read_row_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         cell_char_o,
  output logic               status_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rr_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CH = $clog2(MAX_HEIGHT + 1);

  logic [9:0]    canvas_width_q, canvas_height_q;
  logic [7:0]    background_char_q;
  logic [CW-1:0] cols;
  logic [CH-1:0] rows;
  logic          cfg_write;
  logic [1:0]    reg_idx;

  cmd_t front_cmd, head_cmd;
  logic fifo_full, fifo_empty, fifo_pop, in_beat;

  // apb register file, always ready
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q    <= CANVAS_WIDTH_RST;
      canvas_height_q   <= CANVAS_HEIGHT_RST;
      background_char_q <= BACKGROUND_CHAR_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_CANVAS_WIDTH:    canvas_width_q    <= pwdata[9:0];
        REG_CANVAS_HEIGHT:   canvas_height_q   <= pwdata[9:0];
        REG_BACKGROUND_CHAR: background_char_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CANVAS_WIDTH:    prdata = {22'd0, canvas_width_q};
      REG_CANVAS_HEIGHT:   prdata = {22'd0, canvas_height_q};
      REG_BACKGROUND_CHAR: prdata = {24'd0, background_char_q};
      default:             prdata = 32'd0;
    endcase
  end

  // size in use: zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (canvas_width_q == 10'd0) begin
      cols = CW'(1);
    end else if (int'(canvas_width_q) > MAX_WIDTH) begin
      cols = CW'(MAX_WIDTH);
    end else begin
      cols = CW'(canvas_width_q);
    end
    if (canvas_height_q == 10'd0) begin
      rows = CH'(1);
    end else if (int'(canvas_height_q) > MAX_HEIGHT) begin
      rows = CH'(MAX_HEIGHT);
    end else begin
      rows = CH'(canvas_height_q);
    end
  end

  assign in_stall_o = fifo_full;
  assign in_beat    = in_valid_i && !fifo_full;

  // front end: validity check, edge bounds and read range check
  rr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .kind_i       (kind_i),
    .shape_type_i (shape_type_i),
    .rect_x_i     (rect_x_i),
    .rect_y_i     (rect_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .paint_char_i (paint_char_i),
    .read_col_i   (read_col_i),
    .read_row_i   (read_row_i),
    .cols_i       (cols),
    .rows_i       (rows),
    .cmd_o        (front_cmd)
  );

  rr_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_beat),
    .push_cmd_i(front_cmd),
    .pop_i     (fifo_pop),
    .head_cmd_o(head_cmd),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  // back end: canvas memory, sweep engine and result register
  rr_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_cmd_i       (head_cmd),
    .empty_i          (fifo_empty),
    .pop_o            (fifo_pop),
    .cols_i           (cols),
    .rows_i           (rows),
    .background_char_i(background_char_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_char_o      (cell_char_o),
    .status_o         (status_o)
  );

endmodule
